/* sv/lru_pkg.sv */
// Shared types and constants for the LRU order list.
`timescale 1ns / 1ps

package lru_pkg;

  // Default slab count and fixed item field widths
  localparam int NUM_SLABS_DEF = 1024;
  localparam int ID_W          = 10;
  localparam int TDATA_W       = 16;
  localparam int S_TUSER_W     = 2;
  localparam int M_TUSER_W     = 1;

  // Bit places inside the slave-side tuser
  localparam int TUSER_OP_BIT  = 0;
  localparam int TUSER_SEL_BIT = 1;

  // Operation codes
  typedef enum logic {
    OP_TOUCH = 1'b0,
    OP_POP   = 1'b1
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_T_UNLINK,
    ST_T_RELINK,
    ST_T_LINK,
    ST_P_UNLINK,
    ST_DONE
  } state_t;

endpackage

/* sv/lru_link_ram.sv */
// Link memory: previous and next link tables, one read port, one write port each.
`timescale 1ns / 1ps

module lru_link_ram import lru_pkg::*; #(
  parameter int NUM_SLABS = NUM_SLABS_DEF,
  localparam int ADDR_W   = $clog2(NUM_SLABS),
  localparam int LINK_W   = $clog2(NUM_SLABS + 1)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [LINK_W-1:0] rd_prev,
  output logic [LINK_W-1:0] rd_next,
  input  logic              prev_we,
  input  logic [ADDR_W-1:0] prev_waddr,
  input  logic [LINK_W-1:0] prev_wdata,
  input  logic              next_we,
  input  logic [ADDR_W-1:0] next_waddr,
  input  logic [LINK_W-1:0] next_wdata
);

  logic [LINK_W-1:0] prev_mem [NUM_SLABS];
  logic [LINK_W-1:0] next_mem [NUM_SLABS];

  // Write previous links
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
  end

  // Write next links
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  // Read both links of one entry; hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prev <= prev_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
    end
  end

endmodule

/* sv/lru_order_list.sv */
// Top level of the LRU order list: two doubly linked lists over shared link tables.
`timescale 1ns / 1ps

// Keeps two least-recently-used orderings of slab ids (list 0 memory slabs,
// list 1 disk slabs) in one shared pair of link tables. A touch moves a slab
// id to the tail of the selected list; a pop removes and returns the head.
// Every item gives exactly one result item. After reset the block clears
// every entry of the link tables and takes no item meanwhile. Items are
// handled one at a time by a small sequencer around the link memory, whose
// single write port per table sets the pace: a touch that moves an id passes
// through the unlink, relink and link states, a pop of a non-empty list
// through the unlink state, and a touch of the tail, a touch of an id at or
// above NUM_SLABS, or a pop of an empty list goes straight to the done state.
// A new item is taken while the previous result still waits in the output reg.

module lru_order_list import lru_pkg::*; #(
  parameter int NUM_SLABS = NUM_SLABS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,   // [9:0] slab_id
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] op, [1] list_sel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,   // [9:0] popped_id
  output logic [M_TUSER_W-1:0] m_axis_tuser    // [0] popped_valid
);

  localparam int ADDR_W = $clog2(NUM_SLABS);
  localparam int LINK_W = $clog2(NUM_SLABS + 1);
  localparam int CMP_W  = (LINK_W > ID_W) ? LINK_W : ID_W;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLABS);

  function automatic logic is_id(input logic [LINK_W-1:0] v);
    return v < NIL;
  endfunction

  state_t state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [LINK_W-1:0] head [2];
  logic [LINK_W-1:0] tail [2];
  logic [LINK_W-1:0] head_next [2];
  logic [LINK_W-1:0] tail_next [2];
  op_t               op_q;
  logic              sel_q;
  logic [LINK_W-1:0] id_q;
  logic [LINK_W-1:0] t_q;
  logic [ID_W-1:0]   res_id;
  logic              res_valid;
  logic [ID_W-1:0]   out_id;
  logic              out_flag;

  // Link memory ports
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [LINK_W-1:0] rd_prev;
  logic [LINK_W-1:0] rd_next;
  logic              prev_we;
  logic [ADDR_W-1:0] prev_waddr;
  logic [LINK_W-1:0] prev_wdata;
  logic              next_we;
  logic [ADDR_W-1:0] next_waddr;
  logic [LINK_W-1:0] next_wdata;

  // Input item fields
  op_t             in_op;
  logic            in_sel;
  logic [ID_W-1:0] in_id;
  logic            accept;
  logic            id_ok;
  logic            id_is_tail;
  logic            out_free;

  assign in_op      = op_t'(s_axis_tuser[TUSER_OP_BIT]);
  assign in_sel     = s_axis_tuser[TUSER_SEL_BIT];
  assign in_id      = s_axis_tdata[ID_W-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign id_ok      = CMP_W'(in_id) < CMP_W'(NUM_SLABS);
  assign id_is_tail = CMP_W'(tail[in_sel]) == CMP_W'(in_id);
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  lru_link_ram #(
    .NUM_SLABS (NUM_SLABS)
  ) u_link_ram (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_prev    (rd_prev),
    .rd_next    (rd_next),
    .prev_we    (prev_we),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(NUM_SLABS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_TOUCH) begin
            state_next = (id_ok && !id_is_tail) ? ST_T_UNLINK : ST_DONE;
          end else begin
            state_next = is_id(head[in_sel]) ? ST_P_UNLINK : ST_DONE;
          end
        end
      end
      ST_T_UNLINK: state_next = ST_T_RELINK;
      ST_T_RELINK: state_next = ST_T_LINK;
      ST_T_LINK:   state_next = ST_DONE;
      ST_P_UNLINK: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory accesses and head/tail updates per state
  always_comb begin
    rd_en      = accept;
    rd_addr    = (in_op == OP_TOUCH) ? ADDR_W'(in_id) : head[in_sel][ADDR_W-1:0];
    prev_we    = 1'b0;
    prev_waddr = id_q[ADDR_W-1:0];
    prev_wdata = NIL;
    next_we    = 1'b0;
    next_waddr = id_q[ADDR_W-1:0];
    next_wdata = NIL;
    head_next  = head;
    tail_next  = tail;
    case (state)
      ST_CLEAR: begin
        prev_we    = 1'b1;
        prev_waddr = clr_cnt;
        next_we    = 1'b1;
        next_waddr = clr_cnt;
      end
      ST_T_UNLINK: begin
        // bridge the predecessor over the id, or repair a head
        if (is_id(rd_prev)) begin
          next_we    = 1'b1;
          next_waddr = rd_prev[ADDR_W-1:0];
          next_wdata = rd_next;
        end else begin
          for (int k = 0; k < 2; k++) begin
            if (head[k] == id_q) head_next[k] = rd_next;
          end
        end
        if (!is_id(rd_next)) begin
          for (int k = 0; k < 2; k++) begin
            if (tail[k] == id_q) tail_next[k] = rd_prev;
          end
        end
        // append behind the current tail of the selected list
        prev_we    = 1'b1;
        prev_wdata = tail[sel_q];
        if (!is_id(tail[sel_q])) head_next[sel_q] = id_q;
        tail_next[sel_q] = id_q;
      end
      ST_T_RELINK: begin
        if (is_id(rd_next)) begin
          prev_we    = 1'b1;
          prev_waddr = rd_next[ADDR_W-1:0];
          prev_wdata = rd_prev;
        end
        next_we = 1'b1;
      end
      ST_T_LINK: begin
        if (is_id(t_q)) begin
          next_we    = 1'b1;
          next_waddr = t_q[ADDR_W-1:0];
          next_wdata = id_q;
        end
      end
      ST_P_UNLINK: begin
        // the head's previous link is already null
        next_we    = 1'b1;
        next_waddr = head[sel_q][ADDR_W-1:0];
        if (is_id(rd_next)) begin
          prev_we          = 1'b1;
          prev_waddr       = rd_next[ADDR_W-1:0];
          head_next[sel_q] = rd_next;
        end else begin
          head_next[sel_q] = NIL;
          tail_next[sel_q] = NIL;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and list ends
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      for (int k = 0; k < 2; k++) begin
        head[k] <= NIL;
        tail[k] <= NIL;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Capture the item and build its result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= in_op;
      sel_q     <= in_sel;
      id_q      <= LINK_W'(in_id);
      res_id    <= '0;
      res_valid <= 1'b0;
    end
    if (state == ST_T_UNLINK) t_q <= tail[sel_q];
    if (state == ST_P_UNLINK) begin
      res_id    <= ID_W'(head[sel_q]);
      res_valid <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_id   <= res_id;
      out_flag <= res_valid;
    end
  end

  assign m_axis_tdata = TDATA_W'(out_id);
  assign m_axis_tuser = M_TUSER_W'(out_flag);

  // A list is empty at its head exactly when it is empty at its tail
  a_ends_list0: assert property (@(posedge clk) disable iff (rst)
    (head[0] == NIL) == (tail[0] == NIL))
    else $error("list 0 head and tail disagree on emptiness");

  a_ends_list1: assert property (@(posedge clk) disable iff (rst)
    (head[1] == NIL) == (tail[1] == NIL))
    else $error("list 1 head and tail disagree on emptiness");

  // A moving touch never works on the id that already is the tail
  a_touch_not_tail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_T_UNLINK) |-> (op_q == OP_TOUCH && tail[sel_q] != id_q))
    else $error("touch relinks the current tail");

  // A result without a popped entry carries a zero id
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("result without a popped entry carries an id");

endmodule
